>>> design/lcd_init_and_window_fill_sequencer_macros.svh
// Assertion macros shared by the sequencer modules.
`ifndef LCD_INIT_AND_WINDOW_FILL_SEQUENCER_MACROS_SVH
`define LCD_INIT_AND_WINDOW_FILL_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCDSEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdseq: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LCDSEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdseq: next-cycle check failed");

`endif

>>> design/lcdseq_pkg.sv
// Types, codes and the init command table of the LCD sequencer.
package lcdseq_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_INIT = 2'd1;
   localparam logic [1:0] KIND_FILL = 2'd2;

   localparam logic [5:0] INIT_LEN        = 6'd35;
   localparam logic [5:0] WINDOW_LEN      = 6'd11;
   localparam logic [5:0] WIN_STEP_CASET  = 6'd0;
   localparam logic [5:0] WIN_STEP_X0_HI  = 6'd1;
   localparam logic [5:0] WIN_STEP_X0_LO  = 6'd2;
   localparam logic [5:0] WIN_STEP_X1_HI  = 6'd3;
   localparam logic [5:0] WIN_STEP_X1_LO  = 6'd4;
   localparam logic [5:0] WIN_STEP_RASET  = 6'd5;
   localparam logic [5:0] WIN_STEP_Y0_HI  = 6'd6;
   localparam logic [5:0] WIN_STEP_Y0_LO  = 6'd7;
   localparam logic [5:0] WIN_STEP_Y1_HI  = 6'd8;
   localparam logic [5:0] WIN_STEP_Y1_LO  = 6'd9;
   localparam logic [5:0] WIN_STEP_RAMWR  = 6'd10;

   localparam logic [7:0] CMD_CASET = 8'h2A;
   localparam logic [7:0] CMD_RASET = 8'h2B;
   localparam logic [7:0] CMD_RAMWR = 8'h2C;

   typedef enum logic [1:0] {
      ACT_SEND    = 2'd0,
      ACT_RST_ON  = 2'd1,
      ACT_RST_OFF = 2'd2,
      ACT_WAIT    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_INIT = 2'd1,
      MODE_FILL = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CLS_TICK = 2'd0,
      CLS_INIT = 2'd1,
      CLS_FILL = 2'd2
   } class_type;

   // One classified item as it sits in the queue.
   typedef struct packed {
      class_type   cls;
      logic [15:0] x0;
      logic [15:0] x1;
      logic [15:0] y0;
      logic [15:0] y1;
      logic [15:0] color;
      logic [32:0] pixel_bytes;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  value;
      logic        is_data;
   } init_entry_type;

   // Init table: action, byte or wait length, data flag.
   function automatic init_entry_type init_table(input logic [5:0] idx);
      init_entry_type e;
      case (idx)
         6'd0:  e = '{ACT_RST_ON,  8'd0,   1'b0};
         6'd1:  e = '{ACT_WAIT,    8'd20,  1'b0};
         6'd2:  e = '{ACT_RST_OFF, 8'd0,   1'b0};
         6'd3:  e = '{ACT_WAIT,    8'd20,  1'b0};
         6'd4:  e = '{ACT_SEND,    8'h36,  1'b0};
         6'd5:  e = '{ACT_SEND,    8'h60,  1'b1};
         6'd6:  e = '{ACT_SEND,    8'h3A,  1'b0};
         6'd7:  e = '{ACT_SEND,    8'h55,  1'b1};
         6'd8:  e = '{ACT_SEND,    8'hB2,  1'b0};
         6'd9:  e = '{ACT_SEND,    8'h0C,  1'b1};
         6'd10: e = '{ACT_SEND,    8'h0C,  1'b1};
         6'd11: e = '{ACT_SEND,    8'h00,  1'b1};
         6'd12: e = '{ACT_SEND,    8'h33,  1'b1};
         6'd13: e = '{ACT_SEND,    8'h33,  1'b1};
         6'd14: e = '{ACT_SEND,    8'hB7,  1'b0};
         6'd15: e = '{ACT_SEND,    8'h35,  1'b1};
         6'd16: e = '{ACT_SEND,    8'hBB,  1'b0};
         6'd17: e = '{ACT_SEND,    8'h2B,  1'b1};
         6'd18: e = '{ACT_SEND,    8'hC0,  1'b0};
         6'd19: e = '{ACT_SEND,    8'h2C,  1'b1};
         6'd20: e = '{ACT_SEND,    8'hC2,  1'b0};
         6'd21: e = '{ACT_SEND,    8'h01,  1'b1};
         6'd22: e = '{ACT_SEND,    8'hC3,  1'b0};
         6'd23: e = '{ACT_SEND,    8'h0B,  1'b1};
         6'd24: e = '{ACT_SEND,    8'hC4,  1'b0};
         6'd25: e = '{ACT_SEND,    8'h20,  1'b1};
         6'd26: e = '{ACT_SEND,    8'hC6,  1'b0};
         6'd27: e = '{ACT_SEND,    8'h0F,  1'b1};
         6'd28: e = '{ACT_SEND,    8'hD0,  1'b0};
         6'd29: e = '{ACT_SEND,    8'hA4,  1'b1};
         6'd30: e = '{ACT_SEND,    8'hA1,  1'b1};
         6'd31: e = '{ACT_SEND,    8'h21,  1'b0};
         6'd32: e = '{ACT_SEND,    8'h11,  1'b0};
         6'd33: e = '{ACT_WAIT,    8'd120, 1'b0};
         6'd34: e = '{ACT_SEND,    8'h29,  1'b0};
         default: e = '{ACT_SEND,  8'd0,   1'b0};
      endcase
      return e;
   endfunction

endpackage

>>> design/lcdseq_front.sv
// Front end: classifies accepted items and precomputes the fill window.
module lcdseq_front (
   input  logic                         req_valid,
   input  logic [1:0]                   req_kind,
   input  logic [15:0]                  req_x_origin,
   input  logic [15:0]                  req_y_origin,
   input  logic [15:0]                  req_rect_width,
   input  logic [15:0]                  req_rect_height,
   input  logic [15:0]                  req_pixel_color,
   input  lcdseq_pkg::queue_status_type q_status,
   output logic                         req_stall,
   output logic                         push,
   output lcdseq_pkg::entry_type        push_entry
);
   import lcdseq_pkg::*;

   logic        accept;
   logic [31:0] pixel_count;

   assign req_stall   = q_status.full;
   assign accept      = req_valid & ~q_status.full;
   assign pixel_count = 32'(req_rect_width) * 32'(req_rect_height);

   always_comb begin
      push             = 1'b0;
      push_entry.cls   = CLS_TICK;
      push_entry.x0    = req_x_origin;
      push_entry.x1    = req_x_origin + req_rect_width - 16'd1;
      push_entry.y0    = req_y_origin;
      push_entry.y1    = req_y_origin + req_rect_height - 16'd1;
      push_entry.color = req_pixel_color;
      push_entry.pixel_bytes = {pixel_count, 1'b0};
      case (req_kind)
         KIND_TICK: begin
            push           = accept;
            push_entry.cls = CLS_TICK;
         end
         KIND_INIT: begin
            push           = accept;
            push_entry.cls = CLS_INIT;
         end
         KIND_FILL: begin
            push           = accept;
            push_entry.cls = CLS_FILL;
         end
         // unused kind: take it and drop it
         default: push = 1'b0;
      endcase
   end

endmodule

>>> design/lcdseq_queue.sv
// Short queue of classified items between front and back.
`include "lcd_init_and_window_fill_sequencer_macros.svh"
module lcdseq_queue #(
   parameter int DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  lcdseq_pkg::entry_type        push_entry,
   input  logic                         pop,
   output lcdseq_pkg::entry_type        head_entry,
   output lcdseq_pkg::queue_status_type status
);
   import lcdseq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full      = (count_ff == CNT_FULL);
   assign status.not_empty = (count_ff != '0);
   assign head_entry       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `LCDSEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)
   `LCDSEQ_ASSERT_NOW(a_no_push_full, clock, reset, push, count_ff != CNT_FULL)
   `LCDSEQ_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, count_ff != '0)

endmodule

>>> design/lcdseq_back.sv
// Back end: runs init table and window fill, one action per tick item.
`include "lcd_init_and_window_fill_sequencer_macros.svh"
module lcdseq_back (
   input  logic                         clock,
   input  logic                         reset,
   input  lcdseq_pkg::queue_status_type q_status,
   input  lcdseq_pkg::entry_type        head_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_action,
   output logic [7:0]                   rsp_byte_value,
   output logic                         rsp_is_data,
   output logic                         rsp_frame_end,
   output logic [6:0]                   rsp_wait_ms,
   output logic                         rsp_last
);
   import lcdseq_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [5:0]  step_ff, step_in;
   logic [15:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [15:0] color_ff, color_in;
   logic [32:0] left_ff, left_in;

   logic        rsp_valid_ff, rsp_valid_in;
   action_type  act_ff, act_in;
   logic [7:0]  byte_ff, byte_in;
   logic        dc_ff, dc_in;
   logic        fe_ff, fe_in;
   logic [6:0]  ms_ff, ms_in;
   logic        last_ff, last_in;

   logic           out_free;
   logic           emit;
   init_entry_type tab;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign pop      = q_status.not_empty & out_free;
   assign tab      = init_table(step_ff);

   always_comb begin
      mode_in  = mode_ff;
      step_in  = step_ff;
      x0_in    = x0_ff;
      x1_in    = x1_ff;
      y0_in    = y0_ff;
      y1_in    = y1_ff;
      color_in = color_ff;
      left_in  = left_ff;
      emit     = 1'b0;
      act_in   = ACT_SEND;
      byte_in  = 8'd0;
      dc_in    = 1'b0;
      fe_in    = 1'b0;
      ms_in    = 7'd0;
      last_in  = 1'b0;

      if (pop) begin
         case (head_entry.cls)
            CLS_INIT: begin
               if (mode_ff == MODE_IDLE) begin
                  mode_in = MODE_INIT;
                  step_in = 6'd0;
               end
            end
            CLS_FILL: begin
               if (mode_ff == MODE_IDLE) begin
                  mode_in  = MODE_FILL;
                  step_in  = 6'd0;
                  x0_in    = head_entry.x0;
                  x1_in    = head_entry.x1;
                  y0_in    = head_entry.y0;
                  y1_in    = head_entry.y1;
                  color_in = head_entry.color;
                  left_in  = head_entry.pixel_bytes;
               end
            end
            CLS_TICK: begin
               case (mode_ff)
                  MODE_INIT: begin
                     if (step_ff >= INIT_LEN) begin
                        mode_in = MODE_IDLE;
                        step_in = 6'd0;
                     end else begin
                        emit    = 1'b1;
                        act_in  = tab.action;
                        last_in = (step_ff == INIT_LEN - 6'd1);
                        case (tab.action)
                           ACT_SEND: begin
                              byte_in = tab.value;
                              dc_in   = tab.is_data;
                              fe_in   = 1'b1;
                           end
                           ACT_WAIT: ms_in = tab.value[6:0];
                           default:  ms_in = 7'd0;
                        endcase
                        step_in = step_ff + 6'd1;
                        if (last_in) begin
                           mode_in = MODE_IDLE;
                           step_in = 6'd0;
                        end
                     end
                  end
                  MODE_FILL: begin
                     if (step_ff < WINDOW_LEN) begin
                        emit   = 1'b1;
                        act_in = ACT_SEND;
                        fe_in  = 1'b1;
                        dc_in  = 1'b1;
                        case (step_ff)
                           WIN_STEP_CASET: begin
                              byte_in = CMD_CASET;
                              dc_in   = 1'b0;
                           end
                           WIN_STEP_X0_HI: byte_in = x0_ff[15:8];
                           WIN_STEP_X0_LO: byte_in = x0_ff[7:0];
                           WIN_STEP_X1_HI: byte_in = x1_ff[15:8];
                           WIN_STEP_X1_LO: byte_in = x1_ff[7:0];
                           WIN_STEP_RASET: begin
                              byte_in = CMD_RASET;
                              dc_in   = 1'b0;
                           end
                           WIN_STEP_Y0_HI: byte_in = y0_ff[15:8];
                           WIN_STEP_Y0_LO: byte_in = y0_ff[7:0];
                           WIN_STEP_Y1_HI: byte_in = y1_ff[15:8];
                           WIN_STEP_Y1_LO: byte_in = y1_ff[7:0];
                           WIN_STEP_RAMWR: begin
                              byte_in = CMD_RAMWR;
                              dc_in   = 1'b0;
                              // empty rectangle ends on the write command
                              last_in = (left_ff == '0);
                           end
                           default: byte_in = 8'd0;
                        endcase
                        step_in = step_ff + 6'd1;
                        if (last_in) begin
                           mode_in = MODE_IDLE;
                           step_in = 6'd0;
                        end
                     end else if (left_ff == '0) begin
                        mode_in = MODE_IDLE;
                        step_in = 6'd0;
                     end else begin
                        emit    = 1'b1;
                        act_in  = ACT_SEND;
                        // odd count left: low byte, high byte goes first
                        byte_in = left_ff[0] ? color_ff[7:0] : color_ff[15:8];
                        dc_in   = 1'b1;
                        fe_in   = (left_ff == 33'd1);
                        last_in = fe_in;
                        left_in = left_ff - 33'd1;
                        if (fe_in) begin
                           mode_in = MODE_IDLE;
                           step_in = 6'd0;
                        end
                     end
                  end
                  default: emit = 1'b0;
               endcase
            end
            default: emit = 1'b0;
         endcase
      end

      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         step_ff      <= 6'd0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      y0_ff    <= y0_in;
      y1_ff    <= y1_in;
      color_ff <= color_in;
      if (emit) begin
         act_ff  <= act_in;
         byte_ff <= byte_in;
         dc_ff   <= dc_in;
         fe_ff   <= fe_in;
         ms_ff   <= ms_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = act_ff;
   assign rsp_byte_value = byte_ff;
   assign rsp_is_data    = dc_ff;
   assign rsp_frame_end  = fe_ff;
   assign rsp_wait_ms    = ms_ff;
   assign rsp_last       = last_ff;

   `LCDSEQ_ASSERT_NOW(a_idle_step_zero, clock, reset, mode_ff == MODE_IDLE, step_ff == 6'd0)
   `LCDSEQ_ASSERT_NOW(a_init_step_range, clock, reset, mode_ff == MODE_INIT,
                      step_ff < INIT_LEN)
   `LCDSEQ_ASSERT_NOW(a_fill_pixels_left, clock, reset,
                      (mode_ff == MODE_FILL) && (step_ff >= WINDOW_LEN), left_ff != '0)
   `LCDSEQ_ASSERT_NEXT(a_last_goes_idle, clock, reset, emit && last_in,
                       mode_ff == MODE_IDLE)

endmodule

>>> design/lcd_init_and_window_fill_sequencer.sv
// Top level of the LCD init and window fill sequencer.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | kind, origin, size, color
//   rsp_    | out       | rsp_valid/rsp_stall  | action, byte, D/C, frame end, wait, last
//
// The back end takes one item per cycle while no result waits on rsp_stall.
// An accepted tick shows its action after the queue write, then the output register.
// Reset is synchronous, active high, and empties the queue and returns to idle.
// req_stall rises only when the queue is full; the back end holds while rsp_ is stalled.
// Start items and ticks while idle drain through the queue without a result.
module lcd_init_and_window_fill_sequencer #(
   parameter int QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_x_origin,
   input  logic [15:0] req_y_origin,
   input  logic [15:0] req_rect_width,
   input  logic [15:0] req_rect_height,
   input  logic [15:0] req_pixel_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_is_data,
   output logic        rsp_frame_end,
   output logic [6:0]  rsp_wait_ms,
   output logic        rsp_last
);
   import lcdseq_pkg::*;

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        head_entry;
   logic             push;
   logic             pop;

   lcdseq_front u_front (
      .req_valid       (req_valid),
      .req_kind        (req_kind),
      .req_x_origin    (req_x_origin),
      .req_y_origin    (req_y_origin),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_pixel_color (req_pixel_color),
      .q_status        (q_status),
      .req_stall       (req_stall),
      .push            (push),
      .push_entry      (push_entry)
   );

   lcdseq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   lcdseq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_byte_value (rsp_byte_value),
      .rsp_is_data    (rsp_is_data),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_wait_ms    (rsp_wait_ms),
      .rsp_last       (rsp_last)
   );

endmodule
